>>> design/sbba_pkg.sv
// Package with shared constants, codes and payload types of the swap block allocator.
`default_nettype none

package sbba_pkg;

	// Default geometry of the swap space.
	localparam int SBBA_TOTAL_BLOCKS = 32768;
	localparam int SBBA_GROUP_WIDTH  = 32;

	// Fixed field widths of the request and response words.
	localparam int IDX_W = 15;
	localparam int CNT_W = 32;

	typedef enum logic [1:0] {
		REQ_PAGE_IN  = 2'd0,
		REQ_PAGE_OUT = 2'd1,
		REQ_REMOVE   = 2'd2,
		REQ_STATS    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FREED = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [IDX_W-1:0]   block_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   allocated_block;
		logic [CNT_W-1:0]   page_in_count;
		logic [CNT_W-1:0]   page_out_count;
		logic [CNT_W-1:0]   remove_count;
	} rsp_t;

	// Status flags that the word unit reports about one group word.
	typedef struct packed {
		logic found;        // the word holds at least one free block
		logic bit_set;      // the selected block is marked used
		logic full_before;  // every block of the word is used
		logic full_after;   // every block is used once the selected bit is set
	} word_flags_t;

endpackage

`default_nettype wire

>>> design/sbba_req_if.sv
// Request channel interface: valid, ready and one request word.
`default_nettype none

interface sbba_req_if import sbba_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/sbba_rsp_if.sv
// Response channel interface: valid, ready and one response word.
`default_nettype none

interface sbba_rsp_if import sbba_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/sbba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sbba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/sbba_word_unit.sv
// Shared bit unit: finds the lowest free block of a group word and sets or clears one bit.
`default_nettype none

module sbba_word_unit import sbba_pkg::*; #(
	parameter int GROUP_WIDTH = SBBA_GROUP_WIDTH,
	localparam int BIT_W = $clog2(GROUP_WIDTH)
) (
	input  logic [GROUP_WIDTH-1:0] word,
	input  logic                   find_free,
	input  logic [BIT_W-1:0]       free_pos,
	output logic [BIT_W-1:0]       pos,
	output logic [GROUP_WIDTH-1:0] set_word,
	output logic [GROUP_WIDTH-1:0] clr_word,
	output word_flags_t            flags
);

	logic [BIT_W-1:0]       first_zero;
	logic [GROUP_WIDTH-1:0] mask;

	// Lowest clear bit; scanning downward leaves the lowest one last.
	always_comb begin
		first_zero = '0;
		for (int i = GROUP_WIDTH - 1; i >= 0; i--) begin
			if (!word[i]) begin
				first_zero = BIT_W'(i);
			end
		end
	end

	assign pos      = find_free ? first_zero : free_pos;
	assign mask     = GROUP_WIDTH'(1) << pos;
	assign set_word = word | mask;
	assign clr_word = word & ~mask;

	assign flags.found       = ~&word;
	assign flags.bit_set     = |(word & mask);
	assign flags.full_before = &word;
	assign flags.full_after  = &set_word;

endmodule

`default_nettype wire

>>> design/swap_block_bitmap_allocator_unit.sv
// Top level of the swap block allocator: sequencer, list state, counters and response register.
//
// The block hands out and takes back swap blocks. Blocks sit in groups of GROUP_WIDTH, each
// group with a used-bit word in a block memory; groups that still hold a free block are
// chained in a last-in-first-out list through a second memory of next-group links.
// Requests arrive on the req channel (valid/ready, one word per request) and every request
// gives exactly one response word on the rsp channel: a status, the allocated block for a
// successful page out, and the three operation counters after the request.
// A request is handled as a read and then an execute step: in the cycle it is accepted both
// memories are read at the list head (page out) or at the decoded group (page in, remove);
// in the execute step the shared word unit updates the word, it is written back and the
// response is loaded into the response register. The memory read-modify-write sets the pace:
// a new request is not accepted until the one before has finished its execute step.
// The response register lets a new request be accepted while an older response still waits.
// If the receiver stalls, the block finishes reading the next request's group and then holds
// until the response register drains.
// After reset the block runs a clearing pass over all TOTAL_BLOCKS/GROUP_WIDTH groups (1024 at
// the defaults) that zeroes every group word and links each group to the next; no request word
// is accepted during that pass. The list head, its valid flag and the counters reset at once.
`default_nettype none

module swap_block_bitmap_allocator_unit import sbba_pkg::*; #(
	parameter int TOTAL_BLOCKS = SBBA_TOTAL_BLOCKS,
	parameter int GROUP_WIDTH  = SBBA_GROUP_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	sbba_req_if.sink       req,
	sbba_rsp_if.source     rsp
);

	localparam int NGROUPS     = TOTAL_BLOCKS / GROUP_WIDTH;
	localparam int GIDX_W      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam int NEXT_W      = $clog2(NGROUPS + 1);
	localparam int BIT_W       = $clog2(GROUP_WIDTH);
	localparam int BLOCK_LIMIT = NGROUPS * GROUP_WIDTH;
	// Group number by reciprocal multiply; exact for every 15-bit block index.
	localparam int DIV_SHIFT   = IDX_W + BIT_W;
	localparam int DIV_MULT    = (1 << DIV_SHIFT) / GROUP_WIDTH + 1;
	localparam int PROD_W      = IDX_W + DIV_SHIFT;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t              state_q;
	logic [GIDX_W-1:0]   clr_q;
	logic [GIDX_W-1:0]   head_q;
	logic                nonempty_q;
	req_kind_t           kind_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    grp_q;
	logic [CNT_W-1:0]    ins_q;
	logic [CNT_W-1:0]    outs_q;
	logic [CNT_W-1:0]    rem_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                exec_fire;
	logic [PROD_W-1:0]   div_prod;
	logic [IDX_W-1:0]    quot;
	logic [GIDX_W-1:0]   rd_addr;

	logic                used_we;
	logic [GIDX_W-1:0]   used_waddr;
	logic [GROUP_WIDTH-1:0] used_wdata;
	logic [GROUP_WIDTH-1:0] used_rd;
	logic                next_we;
	logic [GIDX_W-1:0]   next_waddr;
	logic [NEXT_W-1:0]   next_wdata;
	logic [NEXT_W-1:0]   next_rd;

	logic [31:0]         bit_off;
	logic [31:0]         alloc_sum;
	logic                in_range;
	logic [GIDX_W-1:0]   grp_addr;
	logic [BIT_W-1:0]    pos;
	logic [GROUP_WIDTH-1:0] set_word;
	logic [GROUP_WIDTH-1:0] clr_word;
	word_flags_t         flags;

	status_t             status;
	logic [IDX_W-1:0]    blk;
	logic                word_wr;
	logic [GIDX_W-1:0]   word_addr;
	logic [GROUP_WIDTH-1:0] word_data;
	logic                do_pop;
	logic                do_push;
	logic                inc_in;
	logic                inc_out;
	logic                inc_rem;
	logic [CNT_W-1:0]    ins_d;
	logic [CNT_W-1:0]    outs_d;
	logic [CNT_W-1:0]    rem_d;

	// Handshakes.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Read address: the list head for a page out, else the group that holds the block.
	assign div_prod = PROD_W'(req.payload.block_index) * PROD_W'(DIV_MULT);
	assign quot     = div_prod[DIV_SHIFT +: IDX_W];
	assign rd_addr  = (req.payload.req_type == REQ_PAGE_OUT) ? head_q : GIDX_W'(quot);

	sbba_ram #(
		.WIDTH (GROUP_WIDTH),
		.DEPTH (NGROUPS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (used_rd)
	);

	sbba_ram #(
		.WIDTH (NEXT_W),
		.DEPTH (NGROUPS)
	) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	// Block offset inside its group and the range check, from the registered request.
	assign bit_off   = 32'(idx_q) - 32'(grp_q) * 32'(GROUP_WIDTH);
	assign in_range  = 32'(idx_q) < 32'(BLOCK_LIMIT);
	assign grp_addr  = GIDX_W'(grp_q);

	sbba_word_unit #(
		.GROUP_WIDTH (GROUP_WIDTH)
	) u_word_unit (
		.word      (used_rd),
		.find_free (kind_q == REQ_PAGE_OUT),
		.free_pos  (bit_off[BIT_W-1:0]),
		.pos       (pos),
		.set_word  (set_word),
		.clr_word  (clr_word),
		.flags     (flags)
	);

	assign alloc_sum = 32'(head_q) * 32'(GROUP_WIDTH) + 32'(pos);

	// Decision for the request in flight.
	always_comb begin
		status    = STAT_OK;
		blk       = '0;
		word_wr   = 1'b0;
		word_addr = head_q;
		word_data = set_word;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		inc_in    = 1'b0;
		inc_out   = 1'b0;
		inc_rem   = 1'b0;
		case (kind_q)
			REQ_PAGE_OUT: begin
				if (!nonempty_q) begin
					status = STAT_FULL;
				end else if (!flags.found) begin
					// A full group on the list is dropped from it.
					status = STAT_FULL;
					do_pop = 1'b1;
				end else begin
					word_wr = 1'b1;
					blk     = alloc_sum[IDX_W-1:0];
					inc_out = 1'b1;
					do_pop  = flags.full_after;
				end
			end
			REQ_PAGE_IN, REQ_REMOVE: begin
				if (!in_range) begin
					status = STAT_RANGE;
				end else if (!flags.bit_set) begin
					status = STAT_FREED;
				end else begin
					word_wr   = 1'b1;
					word_addr = grp_addr;
					word_data = clr_word;
					do_push   = flags.full_before;
					inc_in    = (kind_q == REQ_PAGE_IN);
					inc_rem   = (kind_q == REQ_REMOVE);
				end
			end
			default: begin
			end
		endcase
	end

	assign ins_d  = ins_q + CNT_W'(inc_in);
	assign outs_d = outs_q + CNT_W'(inc_out);
	assign rem_d  = rem_q + CNT_W'(inc_rem);

	// Memory writes: the clearing pass, or the write-back of the request in flight.
	always_comb begin
		if (state_q == S_CLEAR) begin
			used_we    = 1'b1;
			used_waddr = clr_q;
			used_wdata = '0;
			next_we    = 1'b1;
			next_waddr = clr_q;
			next_wdata = NEXT_W'(clr_q) + NEXT_W'(1);
		end else begin
			used_we    = exec_fire && word_wr;
			used_waddr = word_addr;
			used_wdata = word_data;
			next_we    = exec_fire && do_push;
			next_waddr = grp_addr;
			next_wdata = nonempty_q ? NEXT_W'(head_q) : NEXT_W'(NGROUPS);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == GIDX_W'(NGROUPS - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + GIDX_W'(1);
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// Request registers, taken at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.payload.req_type;
			idx_q  <= req.payload.block_index;
			grp_q  <= quot;
		end
	end

	// Free-group list head and operation counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			nonempty_q <= 1'b1;
			ins_q      <= '0;
			outs_q     <= '0;
			rem_q      <= '0;
		end else if (exec_fire) begin
			ins_q  <= ins_d;
			outs_q <= outs_d;
			rem_q  <= rem_d;
			if (do_pop) begin
				if (next_rd < NEXT_W'(NGROUPS)) begin
					head_q <= GIDX_W'(next_rd);
				end else begin
					head_q     <= '0;
					nonempty_q <= 1'b0;
				end
			end else if (do_push) begin
				head_q     <= grp_addr;
				nonempty_q <= 1'b1;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q.status          <= status;
			rsp_q.allocated_block <= blk;
			rsp_q.page_in_count   <= ins_d;
			rsp_q.page_out_count  <= outs_d;
			rsp_q.remove_count    <= rem_d;
		end
	end

	// A finished request always leaves a response behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> rsp_valid_q)
		else $error("finished request left no response");

	// A stalled receiver holds the request in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && rsp_valid_q && !rsp.ready) |=> (state_q == S_EXEC))
		else $error("request left its execute step while the response was stalled");

	// A granted block lies inside the swap space.
	assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && inc_out) |-> (alloc_sum < 32'(BLOCK_LIMIT)))
		else $error("granted block is outside the swap space");

	// Each successful page out advances its counter by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && inc_out) |=> (outs_q == $past(outs_q) + CNT_W'(1)))
		else $error("page out counter did not advance");

endmodule

`default_nettype wire
